// ----- hw/rtl/usqv_pkg.sv -----
package usqv_pkg;

   // field and datapath widths
   localparam int CNT_W    = 9;
   localparam int IDX_W    = 8;
   localparam int RAD_W    = 16;
   localparam int POS_W    = 17;
   localparam int TEX_W    = 17;
   localparam int SLOT_W   = 3;
   localparam int PHASE_W  = 32;
   localparam int QUO_W    = PHASE_W + 1;
   localparam int TEX_FRAC = 16;
   localparam int X_W      = 31;
   localparam int T_W      = 32;
   localparam int SINE_LAT = 8;
   localparam int REQ_W    = 2 * IDX_W;
   localparam int RSP_W    = 3 * POS_W + 2 * TEX_W + SLOT_W;

   // register reset values
   localparam logic [CNT_W-1:0] RING_COUNT_RST   = 9'd16;
   localparam logic [CNT_W-1:0] SECTOR_COUNT_RST = 9'd16;
   localparam logic [RAD_W-1:0] RADIUS_RST       = 16'd256;

   // quarter-wave sine polynomial, Q30
   localparam logic [X_W-1:0] Q30_ONE      = 31'h4000_0000;
   localparam logic [PHASE_W-1:0] QUARTER  = 32'h4000_0000;
   localparam logic [T_W-1:0] K_C9         = 32'd172272;
   localparam logic [T_W-1:0] POLY_COEF [4] = '{32'd5026995, 32'd85569306,
                                               32'd693598668, 32'd1686629713};

   localparam logic [SLOT_W-1:0] LAST_SLOT = 3'd5;

   typedef enum logic [1:0] {
      REG_RING_COUNT    = 2'd0,
      REG_SECTOR_COUNT  = 2'd1,
      REG_SPHERE_RADIUS = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [TEX_W-1:0]  tex_u;
      logic [TEX_W-1:0]  tex_v;
   } vertex_tag_type;

   // ring offset of each of the six vertices
   function automatic logic ring_step(input logic [SLOT_W-1:0] slot);
      logic step;
      unique case (slot)
         3'd0, 3'd1, 3'd3: step = 1'b0;
         3'd2, 3'd4, 3'd5: step = 1'b1;
         default:          step = 1'b0;
      endcase
      return step;
   endfunction

   // sector offset of each of the six vertices
   function automatic logic sector_step(input logic [SLOT_W-1:0] slot);
      logic step;
      unique case (slot)
         3'd0, 3'd3, 3'd5: step = 1'b0;
         3'd1, 3'd2, 3'd4: step = 1'b1;
         default:          step = 1'b0;
      endcase
      return step;
   endfunction

endpackage

// ----- hw/rtl/usqv_div_cell.sv -----
module usqv_div_cell (
   input  logic                          clock,
   input  logic                          en,
   input  logic [usqv_pkg::CNT_W-1:0]    divisor,
   input  logic [usqv_pkg::CNT_W-1:0]    rem_in,
   input  logic [usqv_pkg::QUO_W-1:0]    quo_in,
   output logic [usqv_pkg::CNT_W-1:0]    rem_out,
   output logic [usqv_pkg::QUO_W-1:0]    quo_out
);
   import usqv_pkg::*;

   logic [CNT_W:0]   shifted;
   logic [CNT_W:0]   diff;
   logic             fits;
   logic [CNT_W-1:0] rem_ff, rem_in_nxt;
   logic [QUO_W-1:0] quo_ff;

   // one restoring step: double the remainder, subtract if it fits
   always_comb begin
      shifted    = {rem_in, 1'b0};
      diff       = shifted - {1'b0, divisor};
      fits       = shifted >= {1'b0, divisor};
      rem_in_nxt = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in_nxt;
         quo_ff <= {quo_in[QUO_W-2:0], fits};
      end
   end

   assign rem_out = rem_ff;
   assign quo_out = quo_ff;

endmodule

// ----- hw/rtl/usqv_div_chain.sv -----
module usqv_div_chain (
   input  logic                          clock,
   input  logic                          en,
   input  logic [usqv_pkg::CNT_W-1:0]    divisor,
   input  logic [usqv_pkg::CNT_W-1:0]    dividend,
   output logic [usqv_pkg::QUO_W-1:0]    quotient,
   output logic [usqv_pkg::CNT_W-1:0]    remainder,
   output logic [usqv_pkg::TEX_W-1:0]    tex
);
   import usqv_pkg::*;

   // quotient of dividend * 2^32 / divisor, one bit per cell, 32 cells deep
   localparam int TAP = PHASE_W - TEX_FRAC;

   logic [CNT_W-1:0] rem_w [PHASE_W+1];
   logic [QUO_W-1:0] quo_w [PHASE_W+1];
   logic             top_bit;
   logic [CNT_W-1:0] half_up;
   logic             tex_rnd;
   logic [TEX_W-1:0] tex_in;
   logic [TEX_W-1:0] tex_ff [TEX_FRAC];

   // integer bit: dividend never exceeds divisor
   always_comb begin
      top_bit  = dividend == divisor;
      rem_w[0] = top_bit ? '0 : dividend;
      quo_w[0] = {{PHASE_W{1'b0}}, top_bit};
   end

   for (genvar i = 0; i < PHASE_W; i++) begin : g_cell
      usqv_div_cell u_cell (
         .clock   (clock),
         .en      (en),
         .divisor (divisor),
         .rem_in  (rem_w[i]),
         .quo_in  (quo_w[i]),
         .rem_out (rem_w[i+1]),
         .quo_out (quo_w[i+1])
      );
   end

   // texture coordinate: 16 fraction bits, rounded half up, taken mid-chain
   always_comb begin
      half_up = divisor - (divisor >> 1);
      tex_rnd = rem_w[TAP] >= half_up;
      tex_in  = quo_w[TAP][TEX_W-1:0] + TEX_W'(tex_rnd);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tex_ff[0] <= tex_in;
         for (int k = 1; k < TEX_FRAC; k++) tex_ff[k] <= tex_ff[k-1];
      end
   end

   assign quotient  = quo_w[PHASE_W];
   assign remainder = rem_w[PHASE_W];
   assign tex       = tex_ff[TEX_FRAC-1];

endmodule

// ----- hw/rtl/usqv_sine.sv -----
module usqv_sine #(
   parameter int FRAC = 15
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [usqv_pkg::PHASE_W-1:0]  phase,
   output logic [FRAC:0]                 mag,
   output logic                          neg
);
   import usqv_pkg::*;

   // eight register stages: fold, square, four Horner steps, final product, round
   localparam int RW = FRAC + 3;
   localparam logic [RW-1:0] MAG_ONE = RW'(1) << FRAC;

   logic [1:0]       quad_ff [7];
   logic [X_W-1:0]   x_ff [6];
   logic [X_W-1:0]   x2_ff [4];
   logic [T_W-1:0]   t_ff [4];
   logic [T_W-1:0]   s_ff;
   logic [FRAC:0]    mag_ff;
   logic             neg_ff;

   logic [X_W-1:0]       x_in;
   logic [2*X_W-1:0]     sq;
   logic [X_W-1:0]       x2_in;
   logic [X_W+T_W-1:0]   prod [4];
   logic [T_W-1:0]       t_in [4];
   logic [X_W+T_W-1:0]   sprod;
   logic [T_W-1:0]       s_in;
   logic [T_W:0]         s_rnd;
   logic [RW-1:0]        r_full;
   logic [FRAC:0]        mag_in;
   logic                 neg_in;

   always_comb begin
      // mirror odd quadrants onto the rising quarter wave
      x_in = phase[PHASE_W-2] ? Q30_ONE - {1'b0, phase[PHASE_W-3:0]}
                              : {1'b0, phase[PHASE_W-3:0]};
      sq    = {{X_W{1'b0}}, x_ff[0]} * {{X_W{1'b0}}, x_ff[0]};
      x2_in = sq[X_W+29:30];
      // Horner steps, each C - x2*t
      for (int k = 0; k < 4; k++) begin
         prod[k] = {{T_W{1'b0}}, x2_ff[k]} *
                   {{X_W{1'b0}}, (k == 0) ? K_C9 : t_ff[(k == 0) ? 0 : k-1]};
         t_in[k] = POLY_COEF[k] - prod[k][T_W+29:30];
      end
      sprod = {{T_W{1'b0}}, x_ff[5]} * {{X_W{1'b0}}, t_ff[3]};
      s_in  = sprod[T_W+29:30];
      // round half up to FRAC bits, cap at one
      s_rnd  = {1'b0, s_ff} + ((T_W+1)'(1) << (29 - FRAC));
      r_full = RW'(s_rnd >> (30 - FRAC));
      mag_in = (r_full > MAG_ONE) ? MAG_ONE[FRAC:0] : r_full[FRAC:0];
      neg_in = quad_ff[6][1] && (mag_in != '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quad_ff[0] <= phase[PHASE_W-1:PHASE_W-2];
         for (int k = 1; k < 7; k++) quad_ff[k] <= quad_ff[k-1];
         x_ff[0] <= x_in;
         for (int k = 1; k < 6; k++) x_ff[k] <= x_ff[k-1];
         x2_ff[0] <= x2_in;
         for (int k = 1; k < 4; k++) x2_ff[k] <= x2_ff[k-1];
         for (int k = 0; k < 4; k++) t_ff[k] <= t_in[k];
         s_ff   <= s_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   assign mag = mag_ff;
   assign neg = neg_ff;

endmodule

// ----- hw/rtl/uv_sphere_quad_vertices.sv -----
// UV sphere cell tessellator.
// req channel: one transfer names a cell (ring, sector). Each index is clamped
// to its count minus one; a count of zero acts as one.
// rsp channel: six vertex transfers per cell in the order (r,s), (r,s+1),
// (r+1,s+1), (r,s), (r+1,s+1), (r+1,s); tlast marks the sixth. Each carries
// position (signed Q8.8) and texture coordinates (Q1.16, 65536 is one).
// csr port: ring_count at 0x0, sector_count at 0x4, sphere_radius at 0x8
// (Q8.8); write only while no cell is in flight.
// Vertices leave on rsp one per cycle while rsp_tready is high, so a new cell
// is taken once per six vertices, set by the single vertex-wide result channel.
// The path is a 32-cell divider chain (one quotient bit per cell), a phase
// register, an 8-stage sine pipe for each of the four angles, two multiply
// stages and the output register. A new cell is taken while the previous
// one's last vertex is still issued. When rsp_tvalid is high and rsp_tready
// is low the whole pipe holds; req_tready then stays low while a cell is being
// issued, so the next cell waits at the sender. Reset empties the pipe and
// loads 16 rings, 16 sectors and radius 1.0.
module uv_sphere_quad_vertices #(
   parameter int MAX_RINGS          = 256,
   parameter int MAX_SECTORS        = 256,
   parameter int TRIG_FRACTION_BITS = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [3:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // ring_index [7:0], sector_index [15:8]
   input  logic [usqv_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // pos_x [16:0], pos_y [33:17], pos_z [50:34], tex_u [67:51], tex_v [84:68],
   // vertex_slot [87:85]
   output logic [usqv_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                         rsp_tlast
);
   import usqv_pkg::*;

   localparam int F      = TRIG_FRACTION_BITS;
   localparam int MW     = F + 1;
   localparam int A_LEN  = PHASE_W;
   localparam int B_LEN  = SINE_LAT + 3;
   localparam int SLOT_LSB = 3 * POS_W + 2 * TEX_W;
   localparam int U_LSB    = 3 * POS_W;
   localparam logic [2*MW-1:0]     HALF_P = (2*MW)'(1) << (F - 1);
   localparam logic [MW+RAD_W-1:0] HALF_R = (MW+RAD_W)'(1) << (F - 1);

   // configuration registers
   logic [CNT_W-1:0] ring_count_ff, sector_count_ff;
   logic [RAD_W-1:0] radius_ff;
   logic             csr_wr;
   reg_index_type    csr_idx;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff   <= RING_COUNT_RST;
         sector_count_ff <= SECTOR_COUNT_RST;
         radius_ff       <= RADIUS_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_RING_COUNT:    ring_count_ff   <= csr_pwdata[CNT_W-1:0];
            REG_SECTOR_COUNT:  sector_count_ff <= csr_pwdata[CNT_W-1:0];
            REG_SPHERE_RADIUS: radius_ff       <= csr_pwdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_RING_COUNT:    csr_prdata = {{(32-CNT_W){1'b0}}, ring_count_ff};
         REG_SECTOR_COUNT:  csr_prdata = {{(32-CNT_W){1'b0}}, sector_count_ff};
         REG_SPHERE_RADIUS: csr_prdata = {{(32-RAD_W){1'b0}}, radius_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // effective counts
   logic [CNT_W-1:0] rings_eff, sectors_eff;

   always_comb begin
      if (ring_count_ff == '0)
         rings_eff = CNT_W'(1);
      else if (32'(ring_count_ff) > MAX_RINGS)
         rings_eff = CNT_W'(MAX_RINGS);
      else
         rings_eff = ring_count_ff;
      if (sector_count_ff == '0)
         sectors_eff = CNT_W'(1);
      else if (32'(sector_count_ff) > MAX_SECTORS)
         sectors_eff = CNT_W'(MAX_SECTORS);
      else
         sectors_eff = sector_count_ff;
   end

   // cell sequencer: issues six vertices, one per advancing cycle
   logic                 adv, req_fire;
   logic                 busy_ff, busy_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [IDX_W-1:0]     ring_ff, sector_ff, ring_clamp, sector_clamp;
   logic [CNT_W-1:0]     ring_lim, sector_lim, vert_ring, vert_sector;
   logic                 rsp_valid_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = !busy_ff || (slot_ff == LAST_SLOT && adv);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      ring_lim     = rings_eff - CNT_W'(1);
      sector_lim   = sectors_eff - CNT_W'(1);
      ring_clamp   = ({1'b0, req_tdata[IDX_W-1:0]} > ring_lim) ? ring_lim[IDX_W-1:0]
                                                              : req_tdata[IDX_W-1:0];
      sector_clamp = ({1'b0, req_tdata[REQ_W-1:IDX_W]} > sector_lim)
                     ? sector_lim[IDX_W-1:0] : req_tdata[REQ_W-1:IDX_W];
      busy_in = busy_ff;
      slot_in = slot_ff;
      if (req_fire) begin
         busy_in = 1'b1;
         slot_in = '0;
      end else if (busy_ff && adv) begin
         if (slot_ff == LAST_SLOT)
            busy_in = 1'b0;
         else
            slot_in = slot_ff + SLOT_W'(1);
      end
      vert_ring   = {1'b0, ring_ff} + CNT_W'(ring_step(slot_ff));
      vert_sector = {1'b0, sector_ff} + CNT_W'(sector_step(slot_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ring_ff   <= ring_clamp;
         sector_ff <= sector_clamp;
      end
   end

   // divider chains: ring angle and v, sector angle and u
   logic [QUO_W-1:0] quo_r, quo_s;
   logic [CNT_W-1:0] rem_s;
   logic [TEX_W-1:0] tex_v, tex_u;

   usqv_div_chain u_ring_div (
      .clock     (clock),
      .en        (adv),
      .divisor   (rings_eff),
      .dividend  (vert_ring),
      .quotient  (quo_r),
      .remainder (),
      .tex       (tex_v)
   );

   usqv_div_chain u_sector_div (
      .clock     (clock),
      .en        (adv),
      .divisor   (sectors_eff),
      .dividend  (vert_sector),
      .quotient  (quo_s),
      .remainder (rem_s),
      .tex       (tex_u)
   );

   // tag lines alongside the chain and the angle datapath
   logic [A_LEN-1:0]  va_ff;
   logic [SLOT_W-1:0] slot_a_ff [A_LEN];
   logic [B_LEN-1:0]  vb_ff;
   vertex_tag_type    tag_b_ff [B_LEN];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= '0;
         vb_ff <= '0;
      end else if (adv) begin
         va_ff <= {va_ff[A_LEN-2:0], busy_ff};
         vb_ff <= {vb_ff[B_LEN-2:0], va_ff[A_LEN-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         slot_a_ff[0] <= slot_ff;
         for (int k = 1; k < A_LEN; k++) slot_a_ff[k] <= slot_a_ff[k-1];
         tag_b_ff[0] <= '{slot: slot_a_ff[A_LEN-1], tex_u: tex_u, tex_v: tex_v};
         for (int k = 1; k < B_LEN; k++) tag_b_ff[k] <= tag_b_ff[k-1];
      end
   end

   // phase stage: theta rounds over 2*rings, phi over sectors
   logic [PHASE_W-1:0] th_in, ph_in;
   logic [PHASE_W-1:0] th_ff, thc_ff, ph_ff, phc_ff;
   logic [QUO_W-1:0]   th_sum;
   logic               ph_rnd;

   always_comb begin
      th_sum = (quo_r + QUO_W'(1)) >> 1;
      th_in  = th_sum[PHASE_W-1:0];
      ph_rnd = rem_s >= (sectors_eff - (sectors_eff >> 1));
      ph_in  = quo_s[PHASE_W-1:0] + PHASE_W'(ph_rnd);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         th_ff  <= th_in;
         thc_ff <= th_in + QUARTER;
         ph_ff  <= ph_in;
         phc_ff <= ph_in + QUARTER;
      end
   end

   // four sine lanes
   logic [F:0] st, ct, sp, cp;
   logic       n_st, n_ct, n_sp, n_cp;

   usqv_sine #(.FRAC(F)) u_sin_th (.clock(clock), .en(adv), .phase(th_ff),
                                   .mag(st), .neg(n_st));
   usqv_sine #(.FRAC(F)) u_cos_th (.clock(clock), .en(adv), .phase(thc_ff),
                                   .mag(ct), .neg(n_ct));
   usqv_sine #(.FRAC(F)) u_sin_ph (.clock(clock), .en(adv), .phase(ph_ff),
                                   .mag(sp), .neg(n_sp));
   usqv_sine #(.FRAC(F)) u_cos_ph (.clock(clock), .en(adv), .phase(phc_ff),
                                   .mag(cp), .neg(n_cp));

   // first products: horizontal scale and y
   logic [2*MW-1:0]     px1_p, pz1_p;
   logic [MW+RAD_W-1:0] py_p;
   logic [MW-1:0]       mx_ff, mz_ff, mx_in, mz_in;
   logic [RAD_W-1:0]    py1_ff, py1_in, py2_ff;
   logic [2:0]          neg1_ff, neg2_ff;

   always_comb begin
      px1_p  = {{MW{1'b0}}, cp} * {{MW{1'b0}}, st} + HALF_P;
      pz1_p  = {{MW{1'b0}}, sp} * {{MW{1'b0}}, st} + HALF_P;
      py_p   = {{RAD_W{1'b0}}, ct} * {{MW{1'b0}}, radius_ff} + HALF_R;
      mx_in  = MW'(px1_p >> F);
      mz_in  = MW'(pz1_p >> F);
      py1_in = RAD_W'(py_p >> F);
   end

   // second products: times the radius
   logic [MW+RAD_W-1:0] px_p, pz_p;
   logic [RAD_W-1:0]    px_ff, pz_ff, px_in, pz_in;

   always_comb begin
      px_p  = {{RAD_W{1'b0}}, mx_ff} * {{MW{1'b0}}, radius_ff} + HALF_R;
      pz_p  = {{RAD_W{1'b0}}, mz_ff} * {{MW{1'b0}}, radius_ff} + HALF_R;
      px_in = RAD_W'(px_p >> F);
      pz_in = RAD_W'(pz_p >> F);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff   <= mx_in;
         mz_ff   <= mz_in;
         py1_ff  <= py1_in;
         // x takes the opposite sign of cos(ph)*sin(th)
         neg1_ff <= {n_sp != n_st, n_ct, n_cp == n_st};
         px_ff   <= px_in;
         pz_ff   <= pz_in;
         py2_ff  <= py1_ff;
         neg2_ff <= neg1_ff;
      end
   end

   // output register
   logic [POS_W-1:0] pos_x_in, pos_y_in, pos_z_in;
   logic [RSP_W-1:0] rsp_data_ff;
   logic             rsp_last_ff;
   vertex_tag_type   tag_out;

   always_comb begin
      tag_out  = tag_b_ff[B_LEN-1];
      pos_x_in = neg2_ff[0] ? POS_W'(0) - {1'b0, px_ff} : {1'b0, px_ff};
      pos_y_in = neg2_ff[1] ? POS_W'(0) - {1'b0, py2_ff} : {1'b0, py2_ff};
      pos_z_in = neg2_ff[2] ? POS_W'(0) - {1'b0, pz_ff} : {1'b0, pz_ff};
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (adv)
         rsp_valid_ff <= vb_ff[B_LEN-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {tag_out.slot, tag_out.tex_v, tag_out.tex_u,
                         pos_z_in, pos_y_in, pos_x_in};
         rsp_last_ff <= tag_out.slot == LAST_SLOT;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   logic rsp_fire;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> slot_ff <= LAST_SLOT)
      else $error("sequencer slot out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid straight after reset");

   a_slot_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_tdata[RSP_W-1:SLOT_LSB] != LAST_SLOT |=>
         rsp_tvalid &&
         rsp_tdata[RSP_W-1:SLOT_LSB] == $past(rsp_tdata[RSP_W-1:SLOT_LSB]) + SLOT_W'(1))
      else $error("vertex of a cell missing from the transfer run");

   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[U_LSB+TEX_W-1:U_LSB] <= TEX_W'(65536))
      else $error("texture u beyond one");
`endif

endmodule
